>>> design/sparse_row_accumulator_macros.svh
// assertion macros for the sparse row accumulator checker
`ifndef SPARSE_ROW_ACCUMULATOR_MACROS_SVH
`define SPARSE_ROW_ACCUMULATOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sparse row accumulator check failed");

// next-cycle implication, disabled while reset is low
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sparse row accumulator check failed");

`endif

>>> design/spr_pkg.sv
// shared constants, types and state codes of the sparse row accumulator
`default_nettype none
package spr_pkg;

    localparam int NUM_COLUMNS = 1024;
    localparam int IDX_W       = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int CNT_W       = $clog2(NUM_COLUMNS + 1);
    localparam int COL_W       = 10;
    localparam int VAL_W       = 32;
    localparam int SUM_W       = 48;
    localparam int FRAC_W      = 16;
    localparam int ENTRY_W     = SUM_W + 1;

    typedef enum logic [0:0] {
        OP_ACCUM = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_DR1,
        S_DR2
    } t_state;

    typedef struct packed {
        t_opcode                  opcode;
        logic [COL_W-1:0]         b_column;
        logic signed [VAL_W-1:0]  a_value;
        logic signed [VAL_W-1:0]  b_value;
    } t_in;

    typedef struct packed {
        logic [COL_W-1:0]         out_column;
        logic signed [SUM_W-1:0]  out_value;
        logic                     is_last;
        logic                     is_empty;
    } t_out;

    typedef struct packed {
        logic load;
        logic first;
    } t_mac_ctl;

endpackage
`default_nettype wire

>>> design/spr_ram.sv
// generic single-write, single-read synchronous ram with registered read
`default_nettype none
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                i_wdata,
    input  wire logic                            i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> design/spr_mac.sv
// q16.16 multiplier with product register and 48-bit saturating adder
`default_nettype none
module spr_mac (
    input  wire logic                             i_clk,
    input  wire spr_pkg::t_mac_ctl                i_ctl,
    input  wire logic signed [spr_pkg::VAL_W-1:0] i_a,
    input  wire logic signed [spr_pkg::VAL_W-1:0] i_b,
    input  wire logic signed [spr_pkg::SUM_W-1:0] i_sum,
    output logic signed [spr_pkg::SUM_W-1:0]      o_next_sum
);

    localparam int PROD_W = 2 * spr_pkg::VAL_W;

    logic signed [PROD_W-1:0]         w_full;
    logic signed [spr_pkg::SUM_W-1:0] r_prod;
    logic signed [spr_pkg::SUM_W:0]   w_wide;
    logic signed [spr_pkg::SUM_W-1:0] w_sat;

    // arithmetic shift right by the fraction width, floor rounding
    assign w_full = PROD_W'(i_a) * PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= w_full[spr_pkg::FRAC_W +: spr_pkg::SUM_W];
        end
    end

    assign w_wide = {i_sum[spr_pkg::SUM_W-1], i_sum} + {r_prod[spr_pkg::SUM_W-1], r_prod};

    always_comb begin
        case (w_wide[spr_pkg::SUM_W -: 2])
            2'b01:   w_sat = {1'b0, {(spr_pkg::SUM_W-1){1'b1}}};
            2'b10:   w_sat = {1'b1, {(spr_pkg::SUM_W-1){1'b0}}};
            default: w_sat = w_wide[spr_pkg::SUM_W-1:0];
        endcase
    end

    assign o_next_sum = i_ctl.first ? r_prod : w_sat;

endmodule
`default_nettype wire

>>> design/sparse_row_accumulator.sv
// top level of the sparse row accumulator: sequencer, entry store and touched list
//
// one output row of a row-wise sparse product is gathered here. an item is taken
// on a rising edge with start high and busy low. an accumulate beat multiplies
// a_value by b_value in q16.16 and adds the product into the entry of b_column,
// saturating to 48 bits; the first touch of a column stores the product and
// appends the column to the touched list. a drain beat returns the next entry
// in first-touch order and clears it; an empty row gives the empty marker.
// accumulate beats that arrive while a row is part drained are dropped.
// an accumulate holds busy through the read-modify-write of the entry ram, entry
// read at acceptance, then write-back in S_ACC. a drain holds busy through S_DR1
// and S_DR2 (list ram read, then entry ram read) and its result strobes from a
// register once S_DR2 is done; an empty drain strobes in the next cycle.
// each result stands on o_result for one cycle with o_result_strobe high; the
// receiver cannot stall, so nothing is held back.
// after reset busy stays high for a clearing pass over all NUM_COLUMNS entries,
// one entry a cycle, which clears every touched flag in the entry ram.
`default_nettype none
module sparse_row_accumulator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire spr_pkg::t_in  i_item,
    output logic               busy,
    output logic               o_result_strobe,
    output spr_pkg::t_out      o_result
);

    localparam int IDX_W   = spr_pkg::IDX_W;
    localparam int CNT_W   = spr_pkg::CNT_W;
    localparam int SUM_W   = spr_pkg::SUM_W;
    localparam int ENTRY_W = spr_pkg::ENTRY_W;

    spr_pkg::t_state r_state, n_state;

    // row bookkeeping
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_dp, n_dp;
    logic [IDX_W-1:0]  r_clr_idx, n_clr_idx;
    logic [IDX_W-1:0]  r_col, n_col;
    logic              r_strobe, n_strobe;
    spr_pkg::t_out     r_out, n_out;

    // entry ram: flag in the top bit, partial sum below
    logic               w_ent_we, w_ent_re;
    logic [IDX_W-1:0]   w_ent_waddr, w_ent_raddr;
    logic [ENTRY_W-1:0] w_ent_wdata, w_ent_rdata;

    // touched list ram
    logic               w_lst_we, w_lst_re;
    logic [IDX_W-1:0]   w_lst_waddr, w_lst_raddr;
    logic [IDX_W-1:0]   w_lst_wdata, w_lst_rdata;

    spr_pkg::t_mac_ctl          w_mac_ctl;
    logic signed [SUM_W-1:0]    w_next_sum;

    logic w_accept;
    logic w_acc_take;
    logic w_drain_empty;
    logic w_flag;
    logic [CNT_W-1:0] w_dp_inc;

    assign w_accept      = start && (r_state == spr_pkg::S_IDLE);
    // column in range and no drain under way
    assign w_acc_take    = (i_item.opcode == spr_pkg::OP_ACCUM) && (r_dp == '0) &&
                           (32'(i_item.b_column) < spr_pkg::NUM_COLUMNS);
    assign w_drain_empty = (r_count == '0) || (r_dp >= r_count);
    assign w_flag        = w_ent_rdata[ENTRY_W-1];
    assign w_dp_inc      = r_dp + CNT_W'(1);

    spr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (spr_pkg::NUM_COLUMNS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_re    (w_ent_re),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    spr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (spr_pkg::NUM_COLUMNS)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (w_lst_we),
        .i_waddr (w_lst_waddr),
        .i_wdata (w_lst_wdata),
        .i_re    (w_lst_re),
        .i_raddr (w_lst_raddr),
        .o_rdata (w_lst_rdata)
    );

    spr_mac u_mac (
        .i_clk      (i_clk),
        .i_ctl      (w_mac_ctl),
        .i_a        (i_item.a_value),
        .i_b        (i_item.b_value),
        .i_sum      (w_ent_rdata[SUM_W-1:0]),
        .o_next_sum (w_next_sum)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spr_pkg::S_CLEAR: begin
                if (r_clr_idx == IDX_W'(spr_pkg::NUM_COLUMNS - 1)) begin
                    n_state = spr_pkg::S_IDLE;
                end
            end
            spr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_item.opcode == spr_pkg::OP_DRAIN) begin
                        if (!w_drain_empty) begin
                            n_state = spr_pkg::S_DR1;
                        end
                    end else if (w_acc_take) begin
                        n_state = spr_pkg::S_ACC;
                    end
                end
            end
            spr_pkg::S_ACC: n_state = spr_pkg::S_IDLE;
            spr_pkg::S_DR1: n_state = spr_pkg::S_DR2;
            spr_pkg::S_DR2: n_state = spr_pkg::S_IDLE;
            default:        n_state = spr_pkg::S_IDLE;
        endcase
    end

    // ram controls and register updates; each write finishes before the next
    // accept reads, so accesses to one entry never overlap
    always_comb begin
        n_count     = r_count;
        n_dp        = r_dp;
        n_clr_idx   = r_clr_idx;
        n_col       = r_col;
        n_strobe    = 1'b0;
        n_out       = r_out;
        w_ent_we    = 1'b0;
        w_ent_waddr = r_col;
        w_ent_wdata = '0;
        w_ent_re    = 1'b0;
        w_ent_raddr = IDX_W'(i_item.b_column);
        w_lst_we    = 1'b0;
        w_lst_waddr = r_count[IDX_W-1:0];
        w_lst_wdata = r_col;
        w_lst_re    = 1'b0;
        w_lst_raddr = r_dp[IDX_W-1:0];
        w_mac_ctl   = '{load: 1'b0, first: !w_flag};
        case (r_state)
            spr_pkg::S_CLEAR: begin
                // sweep the flags clear, one entry a cycle
                w_ent_we    = 1'b1;
                w_ent_waddr = r_clr_idx;
                n_clr_idx   = r_clr_idx + IDX_W'(1);
            end
            spr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_item.opcode == spr_pkg::OP_DRAIN) begin
                        if (w_drain_empty) begin
                            // empty marker, row ends
                            n_count  = '0;
                            n_dp     = '0;
                            n_strobe = 1'b1;
                            n_out    = '{out_column: '0, out_value: '0,
                                         is_last: 1'b1, is_empty: 1'b1};
                        end else begin
                            w_lst_re = 1'b1;
                        end
                    end else if (w_acc_take) begin
                        w_ent_re       = 1'b1;
                        w_mac_ctl.load = 1'b1;
                        n_col          = IDX_W'(i_item.b_column);
                    end
                end
            end
            spr_pkg::S_ACC: begin
                // write back the product or the saturated sum, flag set
                w_ent_we    = 1'b1;
                w_ent_wdata = {1'b1, w_next_sum};
                if (!w_flag && (r_count < CNT_W'(spr_pkg::NUM_COLUMNS))) begin
                    w_lst_we = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            spr_pkg::S_DR1: begin
                // touched column is back, fetch its entry
                w_ent_re    = 1'b1;
                w_ent_raddr = w_lst_rdata;
                n_col       = w_lst_rdata;
            end
            spr_pkg::S_DR2: begin
                // hand out the entry and clear it
                w_ent_we = 1'b1;
                n_strobe = 1'b1;
                n_out    = '{out_column: spr_pkg::COL_W'(r_col),
                             out_value:  w_ent_rdata[SUM_W-1:0],
                             is_last:    (w_dp_inc >= r_count),
                             is_empty:   1'b0};
                if (w_dp_inc >= r_count) begin
                    n_count = '0;
                    n_dp    = '0;
                end else begin
                    n_dp = w_dp_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= spr_pkg::S_CLEAR;
            r_count   <= '0;
            r_dp      <= '0;
            r_clr_idx <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dp      <= n_dp;
            r_clr_idx <= n_clr_idx;
            r_strobe  <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_out <= n_out;
    end

    assign busy            = (r_state != spr_pkg::S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_out;

endmodule
`default_nettype wire

>>> design/spr_checker.sv
// port-level checker for the sparse row accumulator, with its bind
`default_nettype none
`include "sparse_row_accumulator_macros.svh"
module spr_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire spr_pkg::t_in  i_item,
    input wire logic          o_result_strobe,
    input wire spr_pkg::t_out o_result
);

    logic w_acc_beat;
    logic w_drain_beat;

    assign w_acc_beat   = start && !busy && (i_item.opcode == spr_pkg::OP_ACCUM);
    assign w_drain_beat = start && !busy && (i_item.opcode == spr_pkg::OP_DRAIN);

    // empty marker is last and carries zero payload
    `SPR_ASSERT_NOW(a_empty_marker, i_clk, i_rst_n, o_result_strobe && o_result.is_empty, o_result.is_last && (o_result.out_column == '0) && (o_result.out_value == '0))
    // an entry that is not last is never the empty marker
    `SPR_ASSERT_NOW(a_mid_not_empty, i_clk, i_rst_n, o_result_strobe && !o_result.is_last, !o_result.is_empty)
    // no result strobe directly follows an accumulate beat
    `SPR_ASSERT_NEXT(a_acc_silent, i_clk, i_rst_n, w_acc_beat, !o_result_strobe)
    // a drain beat either strobes at once or keeps the block busy
    `SPR_ASSERT_NEXT(a_drain_moves, i_clk, i_rst_n, w_drain_beat, busy || o_result_strobe)

endmodule

bind sparse_row_accumulator spr_checker u_spr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_item          (i_item),
    .o_result_strobe (o_result_strobe),
    .o_result        (o_result)
);
`default_nettype wire
